@@ src/bme_pkg.sv @@
// ----------------------------------------------------------------------------
// bme_pkg
// Types, constants and arithmetic helpers for the bivariate monomial expander.
// ----------------------------------------------------------------------------
package bme_pkg;

    localparam int MAX_DEGREE = 7;
    localparam int TAB_DEPTH  = MAX_DEGREE + 1;
    localparam int EXP_W      = $clog2(TAB_DEPTH);

    localparam logic signed [15:0] Q_ONE     = 16'sd16384;
    localparam logic signed [15:0] Q_NEG_ONE = -16'sd16384;
    localparam logic [2:0]         DEGREE_RESET = 3'd3;

    typedef logic signed [15:0] t_q;

    typedef struct packed {
        t_q         x_value;
        t_q         y_value;
        logic       final_point;
    } t_in_item;

    typedef struct packed {
        t_q         monomial;
        logic [2:0] x_exponent;
        logic [2:0] y_exponent;
        logic       row_last;
        logic       set_last;
    } t_out_item;

    // one slot of the power pipeline
    typedef struct packed {
        t_q                     x;
        t_q                     y;
        logic                   fin;
        logic [EXP_W-1:0]       deg;
        t_q [TAB_DEPTH-1:0]     xp;
        t_q [TAB_DEPTH-1:0]     yp;
    } t_pw_slot;

    function automatic t_q sat_in(input t_q v);
        if (v > Q_ONE)          return Q_ONE;
        else if (v < Q_NEG_ONE) return Q_NEG_ONE;
        else                    return v;
    endfunction

    // Q1.14 product, round half up, saturate to +-1.0
    function automatic t_q q_mul(input t_q a, input t_q b);
        logic signed [31:0] p;
        logic signed [32:0] r;
        logic signed [18:0] sh;
        p  = a * b;
        r  = 33'(p) + 33'sd8192;
        sh = 19'(r >>> 14);
        if (sh > 19'sd16384)       return Q_ONE;
        else if (sh < -19'sd16384) return Q_NEG_ONE;
        else                       return sh[15:0];
    endfunction

    function automatic logic [EXP_W-1:0] eff_degree(input logic [2:0] deg);
        logic [EXP_W+2:0] w;
        w = {{EXP_W{1'b0}}, deg};
        if (w > (EXP_W+3)'(MAX_DEGREE)) w = (EXP_W+3)'(MAX_DEGREE);
        return w[EXP_W-1:0];
    endfunction

    function automatic logic [2:0] exp_field(input logic [EXP_W-1:0] e);
        logic [EXP_W+2:0] w;
        w = {3'b000, e};
        return w[2:0];
    endfunction

endpackage

@@ src/bivariate_monomial_expander.sv @@
// ----------------------------------------------------------------------------
// bivariate_monomial_expander
// Emits one Vandermonde row of total degree D for each (x, y) point.
// ----------------------------------------------------------------------------
// Each accepted point yields (D+1)(D+2)/2 monomials (10 at the reset degree
// of 3, 36 at degree 7), one per cycle while the output is not stalled, as
// set by the single monomial multiplier. Powers x^k and y^k are built in a
// MAX_DEGREE+1 deep pipeline with one x and one y multiply in each stage after
// the first, so later points are taken in and prepared while the current row
// is still going out. From the pipeline a point passes to the emitter, the
// issue stage and the output stage. The degree register (reset 3, limited to
// MAX_DEGREE) must only be written while no point is in flight.
module bivariate_monomial_expander (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bme_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bme_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_data
);
    import bme_pkg::*;

    logic [2:0]         r_degree;

    t_pw_slot           r_pw [MAX_DEGREE+1];
    t_pw_slot           n_pw [MAX_DEGREE+1];
    logic [MAX_DEGREE:0] r_pv;
    logic [MAX_DEGREE+1:0] w_rdy;

    // emitter
    logic               r_ev;
    logic [EXP_W-1:0]   r_s, r_ex, r_d;
    logic               r_fin;
    t_q [TAB_DEPTH-1:0] r_xt, r_yt;
    logic               w_e_last, w_e_load;
    logic [EXP_W-1:0]   w_ey;

    // issue stage
    logic               r_iv;
    t_q                 r_ia, r_ib;
    logic [2:0]         r_iex, r_iey;
    logic               r_ilast, r_iset;
    logic               w_iss_adv;

    // output stage
    logic               r_ov;
    t_out_item          r_out;
    logic               w_out_adv;

    // ---------------- configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= DEGREE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_degree <= i_cfg_data;
        end
    end

    // ---------------- handshake chain
    assign w_out_adv = !r_ov || !i_out_stall;
    assign w_iss_adv = !r_iv || w_out_adv;
    assign w_e_last  = (r_s == r_d) && (r_ex == '0);
    assign w_e_load  = !r_ev || (w_iss_adv && w_e_last);

    // ready ripples back from the emitter, so walk the stages from the end
    always_comb begin
        w_rdy[MAX_DEGREE+1] = w_e_load;
        for (int j = MAX_DEGREE; j >= 0; j--) begin
            w_rdy[j] = !r_pv[j] || w_rdy[j+1];
        end
    end

    assign o_in_stall = !w_rdy[0];

    // ---------------- power pipeline
    always_comb begin
        n_pw[0].x   = sat_in(i_in_item.x_value);
        n_pw[0].y   = sat_in(i_in_item.y_value);
        n_pw[0].fin = i_in_item.final_point;
        n_pw[0].deg = eff_degree(r_degree);
        for (int k = 0; k < TAB_DEPTH; k++) begin
            n_pw[0].xp[k] = Q_ONE;
            n_pw[0].yp[k] = Q_ONE;
        end
    end

    for (genvar g = 1; g <= MAX_DEGREE; g++) begin : g_pow
        always_comb begin
            n_pw[g]       = r_pw[g-1];
            n_pw[g].xp[g] = q_mul(r_pw[g-1].xp[g-1], r_pw[g-1].x);
            n_pw[g].yp[g] = q_mul(r_pw[g-1].yp[g-1], r_pw[g-1].y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else begin
            if (w_rdy[0]) r_pv[0] <= i_in_valid;
            for (int j = 1; j <= MAX_DEGREE; j++) begin
                if (w_rdy[j]) r_pv[j] <= r_pv[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j <= MAX_DEGREE; j++) begin
            if (w_rdy[j]) r_pw[j] <= n_pw[j];
        end
    end

    // ---------------- emitter: walks s ascending, ex descending
    assign w_ey = r_s - r_ex;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= 1'b0;
            r_s  <= '0;
            r_ex <= '0;
        end else if (w_e_load) begin
            r_ev <= r_pv[MAX_DEGREE];
            r_s  <= '0;
            r_ex <= '0;
        end else if (r_ev && w_iss_adv) begin
            if (r_ex == '0) begin
                r_s  <= r_s + 1'b1;
                r_ex <= r_s + 1'b1;
            end else begin
                r_ex <= r_ex - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_e_load && r_pv[MAX_DEGREE]) begin
            r_d   <= r_pw[MAX_DEGREE].deg;
            r_fin <= r_pw[MAX_DEGREE].fin;
            r_xt  <= r_pw[MAX_DEGREE].xp;
            r_yt  <= r_pw[MAX_DEGREE].yp;
        end
    end

    // ---------------- issue stage: operand fetch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (w_iss_adv) begin
            r_iv <= r_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_iss_adv) begin
            r_ia    <= r_xt[r_ex];
            r_ib    <= r_yt[w_ey];
            r_iex   <= exp_field(r_ex);
            r_iey   <= exp_field(w_ey);
            r_ilast <= w_e_last;
            r_iset  <= w_e_last && r_fin;
        end
    end

    // ---------------- output stage: product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_out_adv) begin
            r_ov <= r_iv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv) begin
            r_out.monomial   <= q_mul(r_ia, r_ib);
            r_out.x_exponent <= r_iex;
            r_out.y_exponent <= r_iey;
            r_out.row_last   <= r_ilast;
            r_out.set_last   <= r_iset;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    // ---------------- assertions
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev |-> (r_s <= r_d) && (r_ex <= r_s))
        else $error("emitter position outside the row");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_pv) && r_ev)
        else $error("input stalled with room in the pipeline");

    a_set_last_row_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.set_last |-> o_out_item.row_last &&
            (o_out_item.x_exponent == 3'd0))
        else $error("set_last without end of row");

endmodule

@@ tb/sv/tb_bivariate_monomial_expander.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bivariate_monomial_expander
// Checks the Vandermonde row expander against a behavioral row predictor.
// Points are fed from a queue through a valid/stall driver with random gaps, none when quiet.
// Each accepted point is expanded into its expected monomials. The monitor
// compares every accepted monomial against the oldest expected one. The
// degree register is stepped through 0..7, and is only written while idle.
// ----------------------------------------------------------------------------
module tb_bivariate_monomial_expander;
    import bme_pkg::*;

    localparam int         CYCLE_LIMIT = 5_000_000;
    localparam int         DRAIN_WAIT  = MAX_DEGREE + 3 + 20;
    localparam longint     UNIT        = 16384;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_data = '0;

    bivariate_monomial_expander dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_in_item   pending_points[$];
    t_out_item  expected_monomials[$];
    logic [2:0] cfg_degree = DEGREE_RESET;
    bit         quiet = 1'b0;
    bit         point_taken = 1'b0;
    int         gap_left = 0;
    int         stall_left = 0;
    int         points_queued = 0;
    int         points_accepted = 0;
    int         monomials_checked = 0;
    int         mismatches = 0;
    int         cycle_count = 0;
    int         settings_run = 0;

    // ------------------------------------------------------------------
    // Row predictor
    // ------------------------------------------------------------------
    function automatic t_q clamp_unit(input longint v);
        if (v > UNIT)       return t_q'(UNIT);
        else if (v < -UNIT) return t_q'(-UNIT);
        else                return t_q'(v);
    endfunction

    // Q1.14 product, round half toward +inf, then clamp
    function automatic t_q qmul_round(input t_q a, input t_q b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return clamp_unit((prod + 8192) >>> 14);
    endfunction

    function automatic void expand_point(input t_in_item p);
        t_q        xs;
        t_q        ys;
        t_q        xpow [TAB_DEPTH];
        t_q        ypow [TAB_DEPTH];
        int        d;
        t_out_item e;
        xs = clamp_unit(longint'(p.x_value));
        ys = clamp_unit(longint'(p.y_value));
        d  = (int'(cfg_degree) > MAX_DEGREE) ? MAX_DEGREE : int'(cfg_degree);
        xpow[0] = t_q'(UNIT);
        ypow[0] = t_q'(UNIT);
        for (int k = 1; k <= d; k++) begin
            xpow[k] = qmul_round(xpow[k-1], xs);
            ypow[k] = qmul_round(ypow[k-1], ys);
        end
        for (int s = 0; s <= d; s++) begin
            for (int ex = s; ex >= 0; ex--) begin
                e.monomial   = qmul_round(xpow[ex], ypow[s-ex]);
                e.x_exponent = 3'(ex);
                e.y_exponent = 3'(s - ex);
                e.row_last   = (s == d) && (ex == 0);
                e.set_last   = e.row_last & p.final_point;
                expected_monomials.push_back(e);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH @%0d: %s", cycle_count, msg);
    endtask

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)      return 0;
        else if (r < 85) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 12);
        else             return $urandom_range(20, 40);
    endfunction

    function automatic t_q rand_coord();
        t_q edges [12] = '{16'sd16384, -16'sd16384, 16'sd0, 16'sd16383, -16'sd16383,
                           16'sd1, -16'sd1, 16'sd32767, -16'sd32768, 16'sd16385,
                           -16'sd16385, 16'sd8192};
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)      return edges[$urandom_range(0, 11)];
        else if (r < 88) return t_q'(int'($urandom_range(0, 32768)) - 16384);
        else             return t_q'($urandom());
    endfunction

    task automatic add_point(input int x, input int y, input bit fin);
        t_in_item p;
        p.x_value     = t_q'(x);
        p.y_value     = t_q'(y);
        p.final_point = fin;
        pending_points.push_back(p);
        points_queued++;
    endtask

    // point sets: mostly well formed, some with scrambled final flags
    task automatic add_random_sets(input int n);
        int left;
        int len;
        bit noisy;
        t_in_item p;
        left = n;
        while (left > 0) begin
            len   = $urandom_range(1, 8);
            noisy = ($urandom_range(0, 99) < 15);
            if (len > left) len = left;
            for (int k = 0; k < len; k++) begin
                p.x_value     = rand_coord();
                p.y_value     = rand_coord();
                p.final_point = noisy ? 1'($urandom()) : (k == len - 1);
                pending_points.push_back(p);
                points_queued++;
            end
            left -= len;
        end
    endtask

    task automatic write_degree(input logic [2:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_degree = d;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        wait (points_accepted == points_queued && expected_monomials.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Point driver
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !point_taken) begin
            // stalled: hold the item
        end else if (gap_left > 0) begin
            i_in_valid <= 1'b0;
            gap_left   <= gap_left - 1;
        end else if (pending_points.size() > 0) begin
            i_in_item  <= pending_points.pop_front();
            i_in_valid <= 1'b1;
            gap_left   <= quiet ? 0 : pick_gap();
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // output back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= pick_gap();
        end else begin
            i_out_stall <= 1'b0;
            stall_left  <= $urandom_range(0, 6);
        end
    end

    // ------------------------------------------------------------------
    // Monitor and prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            point_taken <= 1'b0;
        end else begin
            point_taken <= i_in_valid && !o_in_stall;
            if (o_out_valid && !i_out_stall) begin
                monomials_checked++;
                if (expected_monomials.size() == 0) begin
                    report_mismatch($sformatf("unexpected monomial %0d x^%0d y^%0d",
                        o_out_item.monomial, o_out_item.x_exponent,
                        o_out_item.y_exponent));
                end else begin
                    want = expected_monomials.pop_front();
                    if (o_out_item.monomial !== want.monomial)
                        report_mismatch($sformatf("monomial x^%0d y^%0d: got %0d want %0d",
                            want.x_exponent, want.y_exponent,
                            o_out_item.monomial, want.monomial));
                    if (o_out_item.x_exponent !== want.x_exponent)
                        report_mismatch($sformatf("x_exponent: got %0d want %0d",
                            o_out_item.x_exponent, want.x_exponent));
                    if (o_out_item.y_exponent !== want.y_exponent)
                        report_mismatch($sformatf("y_exponent: got %0d want %0d",
                            o_out_item.y_exponent, want.y_exponent));
                    if (o_out_item.row_last !== want.row_last)
                        report_mismatch($sformatf("row_last: got %b want %b",
                            o_out_item.row_last, want.row_last));
                    if (o_out_item.set_last !== want.set_last)
                        report_mismatch($sformatf("set_last: got %b want %b",
                            o_out_item.set_last, want.set_last));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                expand_point(i_in_item);
                points_accepted++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d monomials still due",
                cycle_count, expected_monomials.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset degree: corners, zero to the zero, coordinates beyond one
        add_point( 16384,  16384, 0);
        add_point(-16384, -16384, 0);
        add_point(     0,      0, 0);
        add_point( 16384, -16384, 0);
        add_point( 32767, -32768, 0);
        add_point( 16385, -16385, 0);
        add_point(-32768,  32767, 0);
        add_point(     1,     -1, 0);
        add_point( 16383, -16383, 0);
        add_point(  8192,  -8192, 0);
        add_point(     0,  16384, 0);
        add_point(-16384,      0, 1);
        add_random_sets(40);
        settings_run++;
        wait_idle();

        // degree zero: one monomial per point
        write_degree(3'd0);
        add_point(     0,      0, 1);
        add_point( 32767,     -1, 0);
        add_point(-32768,  12345, 1);
        add_random_sets(40);
        settings_run++;
        wait_idle();

        // top degree
        write_degree(3'd7);
        add_point( 16384, -16384, 0);
        add_point(-16383,  16383, 0);
        add_point( 12000,  -9000, 0);
        add_point(    -1,      1, 1);
        add_point(     0, -16384, 1);
        add_random_sets(50);
        settings_run++;
        wait_idle();

        quiet = 1'b1;
        write_degree(3'd1);
        add_random_sets(50);
        settings_run++;
        wait_idle();

        quiet = 1'b0;
        write_degree(3'd5);
        add_random_sets(50);
        settings_run++;
        wait_idle();

        write_degree(3'd2);
        add_random_sets(50);
        settings_run++;
        wait_idle();

        write_degree(3'd6);
        add_random_sets(40);
        settings_run++;
        wait_idle();

        quiet = 1'b1;
        write_degree(3'd4);
        add_random_sets(40);
        settings_run++;
        wait_idle();

        quiet = 1'b0;
        write_degree(3'd3);
        add_random_sets(50);
        settings_run++;
        wait_idle();

        $display("Ran %0d points over %0d degree settings (0 through 7), %0d monomials checked",
            points_accepted, settings_run, monomials_checked);
        $display("%0d mismatches in %0d cycles", mismatches, cycle_count);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
